// ===== design/false_color_palette_mapper_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the false-color palette mapper
// Clocked assertion wrappers shared by the checker file.
// ----------------------------------------------------------------------------
`ifndef FALSE_COLOR_PALETTE_MAPPER_TOP_ASSERT_SVH
`define FALSE_COLOR_PALETTE_MAPPER_TOP_ASSERT_SVH

// Property checked only while out of reset.
`define FCPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define FCPM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/fcpm_pkg.sv =====
// ----------------------------------------------------------------------------
// fcpm_pkg
// Types and constants shared by the false-color palette mapper.
// ----------------------------------------------------------------------------
package fcpm_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int SAMPLE_W   = 24;
    localparam int D_W        = 16;
    localparam int SCALE_W    = 10;
    localparam int PROD_W     = SAMPLE_W + SCALE_W;
    localparam int CH_W       = 8;
    localparam int SHIFT_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [SCALE_W-1:0] SCALE          = 10'd1000;
    localparam logic [D_W-1:0]     D_MAX          = 16'hFFFF;
    localparam logic [SHIFT_W-1:0] GRAY_SHIFT_RST = 5'd6;
    localparam logic [SHIFT_W-1:0] GRAY_SHIFT_LIM = 5'd16;

    localparam logic [CH_W-1:0] CH_MAX    = 8'hFF;
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h00;
    localparam logic [CH_W-1:0] CH_HALF   = 8'd128;
    localparam logic [CH_W-1:0] IRON_WRAP = 8'd126;  // 382 mod 256

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAY_SHIFT = 1'b1;

    // Quarter of the intermediate range, bits 13:12
    localparam logic [1:0] QTR_0 = 2'd0;
    localparam logic [1:0] QTR_1 = 2'd1;
    localparam logic [1:0] QTR_2 = 2'd2;
    localparam logic [1:0] QTR_3 = 2'd3;

    // Ironbow blue segment, bits 13:11
    localparam logic [2:0] SEG_0000 = 3'd0;
    localparam logic [2:0] SEG_0800 = 3'd1;
    localparam logic [2:0] SEG_1000 = 3'd2;
    localparam logic [2:0] SEG_3000 = 3'd6;
    localparam logic [2:0] SEG_3800 = 3'd7;

    typedef enum logic [2:0] {
        PAL_IRONBOW   = 3'd0,
        PAL_REDYELLOW = 3'd1,
        PAL_BLUERED   = 3'd2,
        PAL_BLACKRED  = 3'd3,
        PAL_BRBIN     = 3'd4,
        PAL_BGR       = 3'd5,
        PAL_GRAY      = 3'd6,
        PAL_SHIFTGRAY = 3'd7
    } t_palette;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

endpackage

// ===== design/fcpm_map.sv =====
// ----------------------------------------------------------------------------
// fcpm_map
// Combinational sample-to-pixel mapping for all eight palettes.
// ----------------------------------------------------------------------------
module fcpm_map (
    input  logic [fcpm_pkg::SAMPLE_W-1:0] i_sample,
    input  fcpm_pkg::t_palette            i_palette,
    input  logic [fcpm_pkg::SHIFT_W-1:0]  i_gray_shift,
    output fcpm_pkg::t_pixel              o_pixel
);

    logic [fcpm_pkg::PROD_W-1:0]   prod;
    logic [fcpm_pkg::PROD_W-1:0]   prod_sh;
    logic [fcpm_pkg::SAMPLE_W-1:0] samp_sh;
    logic [fcpm_pkg::D_W-1:0]      d_scaled;
    logic [fcpm_pkg::D_W-1:0]      d_plain;
    logic [fcpm_pkg::D_W-1:0]      d;
    logic [fcpm_pkg::D_W-1:0]      d_gray;
    logic [fcpm_pkg::CH_W-1:0]     red_sat;
    logic [fcpm_pkg::CH_W-1:0]     gray_sat;
    logic [fcpm_pkg::CH_W-1:0]     p;
    logic [fcpm_pkg::CH_W-1:0]     q;
    logic [fcpm_pkg::CH_W-1:0]     green_iron;
    logic [fcpm_pkg::CH_W-1:0]     blue_iron;
    logic [1:0]                    qtr;
    logic                          scaled;

    // Intermediate value, saturated to 16 bits
    always_comb begin
        prod    = fcpm_pkg::PROD_W'(i_sample) * fcpm_pkg::PROD_W'(fcpm_pkg::SCALE);
        prod_sh = prod >> fcpm_pkg::FRAC_BITS;
        samp_sh = i_sample >> fcpm_pkg::FRAC_BITS;
        if (prod_sh > fcpm_pkg::PROD_W'(fcpm_pkg::D_MAX)) begin
            d_scaled = fcpm_pkg::D_MAX;
        end else begin
            d_scaled = prod_sh[fcpm_pkg::D_W-1:0];
        end
        if (samp_sh > fcpm_pkg::SAMPLE_W'(fcpm_pkg::D_MAX)) begin
            d_plain = fcpm_pkg::D_MAX;
        end else begin
            d_plain = fcpm_pkg::D_W'(samp_sh);
        end
        scaled = i_palette inside {fcpm_pkg::PAL_IRONBOW, fcpm_pkg::PAL_GRAY};
        d      = scaled ? d_scaled : d_plain;
    end

    // Shared bit fields
    always_comb begin
        qtr     = d[13:12];
        p       = d[11:4];
        q       = {1'b0, d[11:5]};
        red_sat = (|d[15:14]) ? fcpm_pkg::CH_MAX : d[13:6];
        green_iron = d[13] ? d[12:5] : fcpm_pkg::CH_ZERO;
        d_gray  = d >> i_gray_shift;
        if (i_gray_shift >= fcpm_pkg::GRAY_SHIFT_LIM) begin
            gray_sat = fcpm_pkg::CH_ZERO;
        end else if (|d_gray[fcpm_pkg::D_W-1:fcpm_pkg::CH_W]) begin
            gray_sat = fcpm_pkg::CH_MAX;
        end else begin
            gray_sat = d_gray[fcpm_pkg::CH_W-1:0];
        end
        case (d[13:11])
            fcpm_pkg::SEG_0000: blue_iron = d[10:3];
            fcpm_pkg::SEG_0800: blue_iron = fcpm_pkg::IRON_WRAP - p;
            fcpm_pkg::SEG_1000: blue_iron = fcpm_pkg::CH_HALF - p;
            fcpm_pkg::SEG_3000,
            fcpm_pkg::SEG_3800: blue_iron = p;
            default:            blue_iron = fcpm_pkg::CH_ZERO;
        endcase
    end

    always_comb begin
        o_pixel = '0;
        case (i_palette)
            fcpm_pkg::PAL_IRONBOW: begin
                o_pixel = '{red_sat, green_iron, blue_iron};
            end
            fcpm_pkg::PAL_REDYELLOW: begin
                o_pixel = '{red_sat, green_iron, fcpm_pkg::CH_ZERO};
            end
            fcpm_pkg::PAL_BLUERED,
            fcpm_pkg::PAL_BLACKRED: begin
                case (qtr)
                    fcpm_pkg::QTR_0: begin
                        o_pixel.blue = (i_palette == fcpm_pkg::PAL_BLUERED) ?
                                       (q | fcpm_pkg::CH_HALF) : p;
                    end
                    fcpm_pkg::QTR_1: begin
                        o_pixel = '{q, fcpm_pkg::CH_ZERO, fcpm_pkg::CH_MAX - q};
                    end
                    fcpm_pkg::QTR_2: begin
                        o_pixel = '{q | fcpm_pkg::CH_HALF, fcpm_pkg::CH_ZERO,
                                    fcpm_pkg::CH_HALF - q};
                    end
                    default: begin
                        o_pixel = '{fcpm_pkg::CH_MAX, p, fcpm_pkg::CH_ZERO};
                    end
                endcase
            end
            fcpm_pkg::PAL_BRBIN: begin
                o_pixel = '{red_sat, fcpm_pkg::CH_ZERO, red_sat};
            end
            fcpm_pkg::PAL_BGR: begin
                case (qtr)
                    fcpm_pkg::QTR_0: o_pixel = '{fcpm_pkg::CH_ZERO, p, fcpm_pkg::CH_MAX};
                    fcpm_pkg::QTR_1: o_pixel = '{fcpm_pkg::CH_ZERO, fcpm_pkg::CH_MAX,
                                                 fcpm_pkg::CH_MAX - p};
                    fcpm_pkg::QTR_2: o_pixel = '{p, fcpm_pkg::CH_MAX, fcpm_pkg::CH_ZERO};
                    default:         o_pixel = '{fcpm_pkg::CH_MAX, fcpm_pkg::CH_MAX - p,
                                                 fcpm_pkg::CH_ZERO};
                endcase
            end
            fcpm_pkg::PAL_GRAY: begin
                // wraps, no saturation
                o_pixel = '{d[13:6], d[13:6], d[13:6]};
            end
            default: begin
                o_pixel = '{gray_sat, gray_sat, gray_sat};
            end
        endcase
    end

endmodule

// ===== design/false_color_palette_mapper_top.sv =====
// ----------------------------------------------------------------------------
// false_color_palette_mapper_top
// Maps an unsigned Q16.8 sample stream to RGB pixels through one of eight
// palettes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_stall carries i_sample and i_last_pixel; a
//   transfer happens on a rising edge with i_valid high and o_stall low.
//   Output channel o_valid / i_stall carries o_red, o_green, o_blue and
//   o_last_pixel_out, which is a copy of i_last_pixel.
//   The path runs through an input register, the palette logic with its
//   single 24x10 multiply, then the result register.
//   Throughput is one pixel per cycle while the receiver does not stall; an
//   empty input register takes a new sample while the previous result waits.
//   When the receiver stalls, the result register holds and the input
//   register fills; o_stall rises only once both are occupied.
//   Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) go straight to
//   the palette select and gray shift registers; write them only while
//   the pipeline is empty.
//   Synchronous reset empties the pipeline and loads palette ironbow and a
//   gray shift of 6.
// ----------------------------------------------------------------------------
module false_color_palette_mapper_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [fcpm_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                            i_last_pixel,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [fcpm_pkg::CH_W-1:0]       o_red,
    output logic [fcpm_pkg::CH_W-1:0]       o_green,
    output logic [fcpm_pkg::CH_W-1:0]       o_blue,
    output logic                            o_last_pixel_out,
    input  logic                            i_cfg_we,
    input  logic [fcpm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fcpm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    fcpm_pkg::t_palette            r_palette;
    logic [fcpm_pkg::SHIFT_W-1:0]  r_gray_shift;

    logic                          r_in_valid;
    logic [fcpm_pkg::SAMPLE_W-1:0] r_sample;
    logic                          r_last;

    logic                          r_out_valid;
    fcpm_pkg::t_pixel              r_pixel;
    logic                          r_out_last;

    fcpm_pkg::t_pixel              n_pixel;
    logic                          out_ready;
    logic                          in_ready;

    assign out_ready = !r_out_valid || !i_stall;
    assign in_ready  = !r_in_valid || out_ready;
    assign o_stall   = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette    <= fcpm_pkg::PAL_IRONBOW;
            r_gray_shift <= fcpm_pkg::GRAY_SHIFT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fcpm_pkg::CFG_PALETTE:    r_palette    <= fcpm_pkg::t_palette'(i_cfg_data[2:0]);
                fcpm_pkg::CFG_GRAY_SHIFT: r_gray_shift <= i_cfg_data[fcpm_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    fcpm_map u_map (
        .i_sample     (r_sample),
        .i_palette    (r_palette),
        .i_gray_shift (r_gray_shift),
        .o_pixel      (n_pixel)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_sample <= i_sample;
            r_last   <= i_last_pixel;
        end
    end

    // Result register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_in_valid) begin
            r_pixel    <= n_pixel;
            r_out_last <= r_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_red            = r_pixel.red;
    assign o_green          = r_pixel.green;
    assign o_blue           = r_pixel.blue;
    assign o_last_pixel_out = r_out_last;

endmodule

// ===== design/fcpm_checker.sv =====
// ----------------------------------------------------------------------------
// fcpm_checker
// Port-level checks for the false-color palette mapper, bound to the top.
// ----------------------------------------------------------------------------
`include "false_color_palette_mapper_top_assert.svh"

module fcpm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [fcpm_pkg::CH_W-1:0]       o_red,
    input logic [fcpm_pkg::CH_W-1:0]       o_green,
    input logic [fcpm_pkg::CH_W-1:0]       o_blue,
    input logic                            o_last_pixel_out
);

    // A transfer with a free output path shows up after the input and result registers
    property p_latency;
        (i_valid && !o_stall && !i_stall) ##1 !i_stall |=> o_valid;
    endproperty

    // Stalled result holds
    property p_hold;
        (o_valid && i_stall) |=> (o_valid && $stable(o_red) && $stable(o_green) &&
                                  $stable(o_blue) && $stable(o_last_pixel_out));
    endproperty

    // Pipeline is empty right after reset
    `FCPM_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "output valid after reset")

    // Back-pressure only when a result is waiting and the receiver stalls
    `FCPM_ASSERT(a_stall_only_full, o_stall |-> (o_valid && i_stall), "stall with free slot")

    `FCPM_ASSERT(a_latency, p_latency, "result missing")

    `FCPM_ASSERT(a_hold, p_hold, "stalled result changed")

endmodule

bind false_color_palette_mapper_top fcpm_checker u_fcpm_checker (.*);

// ===== sim/tb_false_color_palette_mapper_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_false_color_palette_mapper_top
// Self-checking bench for the false-color palette mapper. A driver feeds
// samples from a pending queue and works out the expected pixel for each
// transfer under the current palette settings. A monitor checks every output
// transfer field by field against the oldest expected pixel. The run steps
// through all palettes, the gray shift extremes and several idle and stall
// patterns.
// ----------------------------------------------------------------------------
module tb_false_color_palette_mapper_top;

    typedef struct packed {
        logic [fcpm_pkg::SAMPLE_W-1:0] sample;
        logic                          last;
    } t_sample_item;

    typedef struct packed {
        fcpm_pkg::t_pixel px;
        logic             last;
    } t_pixel_result;

    localparam int N_PHASES      = 16;
    localparam int PHASE_SAMPLES = 105;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_stall;
    logic [fcpm_pkg::SAMPLE_W-1:0]     i_sample = '0;
    logic                              i_last_pixel = 1'b0;
    logic                              o_valid;
    logic                              i_stall = 1'b0;
    logic [fcpm_pkg::CH_W-1:0]         o_red;
    logic [fcpm_pkg::CH_W-1:0]         o_green;
    logic [fcpm_pkg::CH_W-1:0]         o_blue;
    logic                              o_last_pixel_out;
    logic                              i_cfg_we = 1'b0;
    logic [fcpm_pkg::CFG_IDX_W-1:0]    i_cfg_idx = fcpm_pkg::CFG_PALETTE;
    logic [fcpm_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;

    t_sample_item  pending_q[$];
    t_pixel_result expected_q[$];

    fcpm_pkg::t_palette           cur_pal = fcpm_pkg::PAL_IRONBOW;
    logic [fcpm_pkg::SHIFT_W-1:0] cur_shift = fcpm_pkg::GRAY_SHIFT_RST;
    int idle_pct = 0;
    int stall_pct = 0;
    int n_queued = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;

    false_color_palette_mapper_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample         (i_sample),
        .i_last_pixel     (i_last_pixel),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_red            (o_red),
        .o_green          (o_green),
        .o_blue           (o_blue),
        .o_last_pixel_out (o_last_pixel_out),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Color one sample under the given palette settings.
    function automatic t_pixel_result map_sample(
            input logic [fcpm_pkg::SAMPLE_W-1:0] s,
            input logic                          last,
            input fcpm_pkg::t_palette            pal,
            input logic [fcpm_pkg::SHIFT_W-1:0]  shift);
        t_pixel_result res;
        logic [39:0]   wide;
        logic [15:0]   d;
        logic [15:0]   seg;
        logic [15:0]   shifted;
        logic [7:0]    p;
        logic [7:0]    q;
        logic [7:0]    sat6;
        logic [7:0]    r;
        logic [7:0]    g;
        logic [7:0]    b;
        logic          scaled;
        scaled = pal inside {fcpm_pkg::PAL_IRONBOW, fcpm_pkg::PAL_GRAY};
        wide = scaled ? 40'(s) * 40'd1000 : 40'(s);
        wide = wide >> fcpm_pkg::FRAC_BITS;
        d = (wide > 40'hFFFF) ? 16'hFFFF : wide[15:0];
        seg = d & 16'h3800;
        p = d[11:4];
        q = {1'b0, d[11:5]};
        sat6 = (d[15:14] != 2'b00) ? 8'hFF : d[13:6];
        r = 8'h00;
        g = 8'h00;
        b = 8'h00;
        case (pal)
            fcpm_pkg::PAL_IRONBOW, fcpm_pkg::PAL_REDYELLOW: begin
                r = sat6;
                g = d[13] ? d[12:5] : 8'h00;
                if (pal == fcpm_pkg::PAL_IRONBOW) begin
                    if (seg == 16'h0000)      b = d[10:3];
                    else if (seg == 16'h0800) b = 8'd126 - p;  // 382 wraps to 126
                    else if (seg == 16'h1000) b = 8'd128 - p;
                    else if (d[13:12] == 2'b11) b = p;
                end
            end
            fcpm_pkg::PAL_BLUERED, fcpm_pkg::PAL_BLACKRED: begin
                case (d[13:12])
                    2'b00: b = (pal == fcpm_pkg::PAL_BLUERED) ? q + 8'd128 : p;
                    2'b01: begin
                        r = q;
                        b = 8'd255 - q;
                    end
                    2'b10: begin
                        r = q + 8'd128;
                        b = 8'd128 - q;
                    end
                    default: begin
                        r = 8'hFF;
                        g = p;
                    end
                endcase
            end
            fcpm_pkg::PAL_BRBIN: begin
                r = sat6;
                b = sat6;
            end
            fcpm_pkg::PAL_BGR: begin
                case (d[13:12])
                    2'b00: begin
                        g = p;
                        b = 8'hFF;
                    end
                    2'b01: begin
                        g = 8'hFF;
                        b = 8'd255 - p;
                    end
                    2'b10: begin
                        r = p;
                        g = 8'hFF;
                    end
                    default: begin
                        r = 8'hFF;
                        g = 8'd255 - p;
                    end
                endcase
            end
            fcpm_pkg::PAL_GRAY: begin
                // wraps, no saturation
                r = d[13:6];
                g = r;
                b = r;
            end
            default: begin
                shifted = d >> shift;
                if (shift >= 5'd16)         r = 8'h00;
                else if (shifted > 16'd255) r = 8'hFF;
                else                        r = shifted[7:0];
                g = r;
                b = r;
            end
        endcase
        res.px.red = r;
        res.px.green = g;
        res.px.blue = b;
        res.last = last;
        return res;
    endfunction

    // Mostly in-range values, a share near quarter and segment boundaries, some noise.
    function automatic logic [fcpm_pkg::SAMPLE_W-1:0] random_sample(
            input fcpm_pkg::t_palette pal);
        int   pick;
        int   target;
        logic scaled;
        scaled = pal inside {fcpm_pkg::PAL_IRONBOW, fcpm_pkg::PAL_GRAY};
        pick = $urandom_range(7);
        if (pick == 0) return fcpm_pkg::SAMPLE_W'($urandom());
        if (pick <= 2) begin
            target = 'h800 * $urandom_range(8) + $urandom_range(8) - 4;
            if ($urandom_range(5) == 0) target = 65535 - $urandom_range(3);
            if (target < 0) target = 0;
            if (scaled) return fcpm_pkg::SAMPLE_W'((target * 256 + 999) / 1000);
            return {target[15:0], 8'($urandom())};
        end
        if (scaled) return fcpm_pkg::SAMPLE_W'($urandom_range(17000));
        if (pick < 5) return fcpm_pkg::SAMPLE_W'($urandom_range(24'h3FFFFF));
        return fcpm_pkg::SAMPLE_W'($urandom());
    endfunction

    task automatic queue_sample(input logic [fcpm_pkg::SAMPLE_W-1:0] s, input logic last);
        t_sample_item it;
        it.sample = s;
        it.last = last;
        pending_q.push_back(it);
        n_queued++;
    endtask

    // Wait until every queued sample has been transferred and its pixel checked.
    task automatic drain();
        while (n_sent != n_queued || expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_palette(input logic [fcpm_pkg::CFG_DATA_W-1:0] pal_data,
                                   input logic [fcpm_pkg::CFG_DATA_W-1:0] shift_data);
        drain();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= fcpm_pkg::CFG_PALETTE;
        i_cfg_data <= pal_data;
        @(posedge i_clk);
        i_cfg_idx <= fcpm_pkg::CFG_GRAY_SHIFT;
        i_cfg_data <= shift_data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_pal = fcpm_pkg::t_palette'(pal_data[2:0]);
        cur_shift = shift_data;
    endtask

    task automatic phase_setting(input int ph,
                                 output logic [fcpm_pkg::CFG_DATA_W-1:0] pal_data,
                                 output logic [fcpm_pkg::CFG_DATA_W-1:0] shift_data);
        shift_data = fcpm_pkg::GRAY_SHIFT_RST;
        case (ph)
            0:  pal_data = {2'b00, fcpm_pkg::PAL_IRONBOW};
            1:  pal_data = {2'b00, fcpm_pkg::PAL_REDYELLOW};
            2:  pal_data = {2'b00, fcpm_pkg::PAL_BLUERED};
            3:  pal_data = {2'b00, fcpm_pkg::PAL_BLACKRED};
            4:  pal_data = {2'b00, fcpm_pkg::PAL_BRBIN};
            5:  pal_data = {2'b00, fcpm_pkg::PAL_BGR};
            6:  pal_data = {2'b00, fcpm_pkg::PAL_GRAY};
            7: begin
                pal_data = {2'b00, fcpm_pkg::PAL_SHIFTGRAY};
                shift_data = 5'd0;
            end
            8: begin
                pal_data = {2'b00, fcpm_pkg::PAL_SHIFTGRAY};
                shift_data = 5'd15;
            end
            9: begin
                pal_data = {2'b00, fcpm_pkg::PAL_SHIFTGRAY};
                shift_data = 5'd16;
            end
            10: begin
                pal_data = {2'b00, fcpm_pkg::PAL_SHIFTGRAY};
                shift_data = 5'd31;
            end
            // upper palette bits set: must be ignored
            11: pal_data = {2'b11, fcpm_pkg::PAL_BLUERED};
            12: pal_data = {2'b10, fcpm_pkg::PAL_IRONBOW};
            13: begin
                pal_data = {2'b01, fcpm_pkg::PAL_SHIFTGRAY};
                shift_data = 5'($urandom_range(1, 14));
            end
            14: begin
                pal_data = {2'b11, fcpm_pkg::PAL_GRAY};
                shift_data = 5'($urandom_range(31));
            end
            default: begin
                pal_data = {2'b00, fcpm_pkg::PAL_SHIFTGRAY};
                shift_data = 5'($urandom_range(17, 30));
            end
        endcase
    endtask

    // Driver: record the expected pixel on each input transfer, then advance.
    always @(posedge i_clk) begin : drive_samples
        t_sample_item nxt;
        logic         load;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            load = !i_valid;
            if (i_valid && !o_stall) begin
                expected_q.push_back(map_sample(i_sample, i_last_pixel, cur_pal, cur_shift));
                n_sent++;
                load = 1'b1;
            end
            if (load) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    nxt = pending_q.pop_front();
                    i_sample <= nxt.sample;
                    i_last_pixel <= nxt.last;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Monitor: compare each output transfer with the oldest expected pixel.
    always @(posedge i_clk) begin : check_pixels
        t_pixel_result want;
        logic          bad;
        if (i_rst_n && o_valid && !i_stall) begin
            n_checked++;
            if (expected_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected pixel r=%02h g=%02h b=%02h last=%0b at %0t",
                             o_red, o_green, o_blue, o_last_pixel_out, $realtime);
            end else begin
                want = expected_q.pop_front();
                bad = (o_red !== want.px.red) || (o_green !== want.px.green) ||
                      (o_blue !== want.px.blue) || (o_last_pixel_out !== want.last);
                if (bad) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("pixel %0d: expected r=%02h g=%02h b=%02h last=%0b,",
                                 n_checked, want.px.red, want.px.green, want.px.blue,
                                 want.last,
                                 " got r=%02h g=%02h b=%02h last=%0b",
                                 o_red, o_green, o_blue, o_last_pixel_out);
                end
            end
        end
    end

    initial begin : stimulus
        logic [fcpm_pkg::CFG_DATA_W-1:0] pal_data;
        logic [fcpm_pkg::CFG_DATA_W-1:0] shift_data;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero and full scale on every palette, plus ironbow saturation edge.
        for (int pi = 0; pi < 8; pi++) begin
            program_palette(fcpm_pkg::CFG_DATA_W'(pi), fcpm_pkg::GRAY_SHIFT_RST);
            queue_sample('0, 1'b1);
            queue_sample(24'hFFFFFF, 1'b0);
            if (fcpm_pkg::t_palette'(pi) == fcpm_pkg::PAL_IRONBOW) begin
                queue_sample(24'd16777, 1'b0);
                queue_sample(24'd16778, 1'b1);
                queue_sample(24'hAAAAAA, 1'b0);
                queue_sample(24'h555555, 1'b1);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            phase_setting(ph, pal_data, shift_data);
            program_palette(pal_data, shift_data);
            case (ph % 4)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct = 86;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 86;
                end
                default: begin
                    idle_pct = 8;
                    stall_pct = 8;
                end
            endcase
            for (int k = 0; k < PHASE_SAMPLES; k++)
                queue_sample(random_sample(cur_pal), 1'($urandom()));
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d samples through all 8 palettes over %0d register settings",
                 n_sent, N_PHASES + 8);
        $display("Checked %0d pixels, %0d mismatches, %0d pixels missing",
                 n_checked, n_errors, expected_q.size());
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("timeout after %0d of %0d samples sent", n_sent, n_queued);
        $display("FAIL");
        $finish;
    end

endmodule
